// ===== rtl/led_frame_gamma_power_limiter_unit_macros.svh =====
// Assertion macros shared by the power limiter RTL
`ifndef LED_FRAME_GAMMA_POWER_LIMITER_UNIT_MACROS_SVH
`define LED_FRAME_GAMMA_POWER_LIMITER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LFGPL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LFGPL_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define LFGPL_ASSERT(name, prop, msg)
`define LFGPL_ASSERT_NEVER(name, expr, msg)
`endif
`endif

// ===== rtl/lfgpl_pkg.sv =====
// Types, constants and helper functions of the frame power limiter
package lfgpl_pkg;

  localparam int unsigned MaxPixels = 256;
  localparam int unsigned AddrW     = $clog2(MaxPixels);
  localparam int unsigned CountW    = $clog2(MaxPixels + 1);
  localparam int unsigned SumW      = $clog2(MaxPixels * 1020 + 1);
  localparam int unsigned CostW     = 10;
  localparam int unsigned DriveW    = SumW + CostW;
  localparam int unsigned QuietW    = CountW + 8;
  localparam int unsigned EstW      = DriveW + 1;
  localparam int unsigned ThrW      = 28;
  localparam int unsigned AvailW    = 20;
  localparam int unsigned AvailScW  = AvailW + 8;
  localparam int unsigned RatioW    = 17;
  localparam int unsigned QuoW      = 16;
  localparam int unsigned DivW      = (DriveW > AvailScW) ? DriveW : AvailScW;
  localparam int unsigned RdProdW   = 8 + RatioW;
  localparam int unsigned PaddrW    = 5;
  localparam int unsigned RndQW     = EstW - 4;
  localparam int unsigned RcpW      = 25;
  localparam int unsigned MaProdW   = RndQW + RcpW;

  localparam logic [RatioW-1:0] RatioUnity = RatioW'(65536);
  localparam int unsigned       RoundHalf  = 2040;
  localparam longint unsigned   RndSat     = 64'd4080 * 64'd65536;
  // ceil(2^32 / 255)
  localparam logic [RcpW-1:0]   Recip255   = RcpW'(16843010);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [PaddrW-3:0] {
    REG_GAIN         = 3'd0,
    REG_PIXEL_COUNT  = 3'd1,
    REG_BUDGET       = 3'd2,
    REG_CHANNEL_COST = 3'd3,
    REG_IDLE_COST    = 3'd4,
    REG_REPEATER     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]       gain;
    logic [8:0]       pixel_count;
    logic [15:0]      budget_ma;
    logic [CostW-1:0] channel_cost_q4;
    logic [7:0]       idle_cost_q4;
    logic             repeater_pixel;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic ld_mul;
    logic ld_scale;
    logic ld_sqr;
    logic ld_store;
    logic fn_mul;
    logic fn_sum;
    logic fn_check;
    logic fn_div;
    logic fn_commit;
    logic rd_fetch;
    logic rd_mul;
    logic rd_round;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic load_ok;
    logic need_div;
    logic div_last;
  } dp_stat_t;

  // x/255 for any 16-bit x below 65535
  function automatic logic [8:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[16:8];
  endfunction

endpackage

// ===== rtl/lfgpl_if.sv =====
// Stream interfaces for the command words and the result words
interface lfgpl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] white_in;

  modport source (output valid, command, red_in, green_in, blue_in, white_in, input ready);
  modport sink (input valid, command, red_in, green_in, blue_in, white_in, output ready);
endinterface

interface lfgpl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [7:0]  white_out;
  logic [7:0]  pixel_index;
  logic [15:0] current_ma;
  logic        limited;

  modport source (output valid, red_out, green_out, blue_out, white_out, pixel_index,
                  current_ma, limited, input ready);
  modport sink (input valid, red_out, green_out, blue_out, white_out, pixel_index,
                current_ma, limited, output ready);
endinterface

// ===== rtl/lfgpl_regs.sv =====
// APB configuration register file
module lfgpl_regs import lfgpl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain            <= 8'd255;
      cfg_q.pixel_count     <= 9'd256;
      cfg_q.budget_ma       <= 16'd2000;
      cfg_q.channel_cost_q4 <= CostW'(192);
      cfg_q.idle_cost_q4    <= 8'd16;
      cfg_q.repeater_pixel  <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_GAIN:         cfg_q.gain            <= pwdata[7:0];
        REG_PIXEL_COUNT:  cfg_q.pixel_count     <= pwdata[8:0];
        REG_BUDGET:       cfg_q.budget_ma       <= pwdata[15:0];
        REG_CHANNEL_COST: cfg_q.channel_cost_q4 <= pwdata[CostW-1:0];
        REG_IDLE_COST:    cfg_q.idle_cost_q4    <= pwdata[7:0];
        REG_REPEATER:     cfg_q.repeater_pixel  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN:         prdata = 32'(cfg_q.gain);
      REG_PIXEL_COUNT:  prdata = 32'(cfg_q.pixel_count);
      REG_BUDGET:       prdata = 32'(cfg_q.budget_ma);
      REG_CHANNEL_COST: prdata = 32'(cfg_q.channel_cost_q4);
      REG_IDLE_COST:    prdata = 32'(cfg_q.idle_cost_q4);
      REG_REPEATER:     prdata = 32'(cfg_q.repeater_pixel);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/lfgpl_div.sv =====
// Restoring divider, one quotient bit per cycle while step_i is high
`include "led_frame_gamma_power_limiter_unit_macros.svh"
module lfgpl_div import lfgpl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            step_i,
  input  logic [DivW-1:0] hi_i,
  input  logic [QuoW-1:0] lo_i,
  input  logic [DivW-1:0] den_i,
  output logic [QuoW-1:0] quo_o,
  output logic            last_o
);

  localparam int unsigned CntW = $clog2(QuoW + 1);

  logic [DivW-1:0] rem_q, den_q;
  logic [QuoW-1:0] lo_q, quo_q;
  logic [CntW-1:0] cnt_q;
  logic            active_q;
  logic [DivW:0]   trial;
  logic            ge;

  // hi_i < den_i on start, so the remainder always fits DivW bits
  assign trial  = {rem_q, lo_q[QuoW-1]};
  assign ge     = trial >= {1'b0, den_q};
  assign last_o = cnt_q == CntW'(QuoW - 1);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else if (start_i) begin
      cnt_q    <= '0;
      active_q <= 1'b1;
    end else if (step_i) begin
      cnt_q <= cnt_q + CntW'(1);
      if (last_o) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi_i;
      lo_q  <= lo_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (step_i) begin
      rem_q <= ge ? DivW'(trial - {1'b0, den_q}) : DivW'(trial);
      lo_q  <= lo_q << 1;
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
  end

  `LFGPL_ASSERT(a_div_rem_below_den, active_q |-> (rem_q < den_q), "divider remainder overflow")
  `LFGPL_ASSERT_NEVER(a_div_step_idle, step_i && !active_q, "divider stepped while idle")

endmodule

// ===== rtl/lfgpl_dp.sv =====
// Datapath: gain/gamma, pixel store, current estimate and dimming
`include "led_frame_gamma_power_limiter_unit_macros.svh"
module lfgpl_dp import lfgpl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  dp_cmd_t         cmd_i,
  output dp_stat_t        stat_o,
  input  logic [3:0][7:0] pix_i,
  output logic [3:0][7:0] res_ch_o,
  output logic [7:0]      res_idx_o,
  output logic [15:0]     current_ma_o,
  output logic            limited_o
);

  logic [31:0] store_mem [MaxPixels];

  // frame state
  logic [CountW-1:0] lp_q, rp_q;
  logic [SumW-1:0]   sum_q;
  logic [RatioW-1:0] ratio_q;
  logic              lim_q;
  logic [15:0]       cur_q;

  // working registers
  logic [3:0][7:0]         ch_q, scl_q, res_ch_q, out_ch_q;
  logic [3:0][15:0]        prod_q, sq_q;
  logic [3:0][RdProdW-1:0] rdp_q;
  logic [31:0]             mem_rd_q;
  logic [7:0]              res_idx_q, out_idx_q;
  logic [15:0]             out_cur_q;
  logic                    out_lim_q;
  logic [DriveW-1:0]       drive_q;
  logic [QuietW-1:0]       quiet_q;
  logic [EstW-1:0]         est_q, rnd_q;
  logic [ThrW-1:0]         thresh_q;
  logic [AvailW-1:0]       avail_q;
  logic                    sum_nz_q, use_div_q;

  logic [CountW-1:0]   cnt, rp_eff;
  logic [15:0]         budget_eff;
  logic [3:0][8:0]     scl_full, g_full;
  logic [3:0][7:0]     g_c, dim_c;
  logic [3:0][RdProdW-1:0] rnd_prod;
  logic [EstW-1:0]     est_c;
  logic [AvailW-1:0]   b16;
  logic [AvailScW-1:0] avail_sc;
  logic                lim_c, drive_zero, a_ge, rnd_sat, need_div_c;
  logic [DivW-1:0]     div_hi, div_den;
  logic [QuoW-1:0]     quo;
  logic [MaProdW-1:0]  ma_prod;
  logic [15:0]         ma_quo;

  always_comb begin
    if (cfg_i.pixel_count == '0) begin
      cnt = CountW'(1);
    end else if (32'(cfg_i.pixel_count) > MaxPixels) begin
      cnt = CountW'(MaxPixels);
    end else begin
      cnt = CountW'(cfg_i.pixel_count);
    end
  end

  assign budget_eff = (cfg_i.budget_ma == '0) ? 16'd1 : cfg_i.budget_ma;
  assign rp_eff     = (rp_q >= cnt) ? '0 : rp_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      scl_full[k] = div255(prod_q[k] + 16'd127);
      g_full[k]   = div255(sq_q[k]);
      g_c[k]      = g_full[k][7:0];
      rnd_prod[k] = rdp_q[k] + RdProdW'(32768);
      dim_c[k]    = (rnd_prod[k][RdProdW-1:16] > 9'd255) ? 8'd255 : rnd_prod[k][23:16];
    end
  end

  // finish arithmetic
  assign est_c = EstW'(drive_q) + (EstW'(quiet_q) << 8) - EstW'(quiet_q);
  assign b16   = AvailW'(budget_eff) << 4;

  assign avail_sc   = (AvailScW'(avail_q) << 8) - AvailScW'(avail_q);
  assign lim_c      = (64'(est_q) > 64'(thresh_q)) && sum_nz_q;
  assign drive_zero = drive_q == '0;
  assign a_ge       = 64'(avail_sc) >= 64'(drive_q);
  assign rnd_sat    = 64'(rnd_q) >= RndSat;
  assign need_div_c = lim_c && !drive_zero && !a_ge;

  // x/4080 as (x/16)/255; the reciprocal is exact while x/16 is below 255*65536
  assign ma_prod = MaProdW'(rnd_q[EstW-1:4]) * MaProdW'(Recip255);
  assign ma_quo  = ma_prod[32 +: 16];

  assign div_hi  = DivW'(avail_sc);
  assign div_den = DivW'(drive_q);

  lfgpl_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (cmd_i.fn_check && need_div_c),
    .step_i  (cmd_i.fn_div),
    .hi_i    (div_hi),
    .lo_i    ('0),
    .den_i   (div_den),
    .quo_o   (quo),
    .last_o  (stat_o.div_last)
  );

  assign stat_o.load_ok  = lp_q < cnt;
  assign stat_o.need_div = need_div_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q    <= '0;
      rp_q    <= '0;
      sum_q   <= '0;
      ratio_q <= RatioUnity;
      lim_q   <= 1'b0;
      cur_q   <= '0;
    end else if (cmd_i.ld_store) begin
      lp_q  <= lp_q + CountW'(1);
      sum_q <= sum_q + SumW'(g_c[0]) + SumW'(g_c[1]) + SumW'(g_c[2]) + SumW'(g_c[3]);
    end else if (cmd_i.fn_check) begin
      lim_q   <= lim_c;
      cur_q   <= lim_c ? budget_eff : (rnd_sat ? 16'hFFFF : ma_quo);
      ratio_q <= (lim_c && drive_zero) ? '0 : RatioUnity;
    end else if (cmd_i.fn_commit) begin
      if (use_div_q) begin
        ratio_q <= RatioW'(quo);
      end
      sum_q <= '0;
      lp_q  <= '0;
      rp_q  <= '0;
    end else if (cmd_i.rd_fetch) begin
      rp_q <= rp_eff + CountW'(1);
    end
  end

  // pixel store
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_store) begin
      store_mem[lp_q[AddrW-1:0]] <= g_c;
    end
    if (cmd_i.rd_fetch) begin
      mem_rd_q <= store_mem[rp_eff[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q <= pix_i;
    end
    for (int k = 0; k < 4; k++) begin
      if (cmd_i.ld_mul) begin
        prod_q[k] <= 16'(ch_q[k]) * 16'(cfg_i.gain);
      end
      if (cmd_i.ld_scale) begin
        scl_q[k] <= scl_full[k][7:0];
      end
      if (cmd_i.ld_sqr) begin
        sq_q[k] <= 16'(scl_q[k]) * 16'(scl_q[k]);
      end
      if (cmd_i.rd_mul) begin
        rdp_q[k] <= RdProdW'(mem_rd_q[8*k +: 8]) * RdProdW'(ratio_q);
      end
    end
    if (cmd_i.fn_mul) begin
      drive_q <= DriveW'(sum_q) * DriveW'(cfg_i.channel_cost_q4);
      quiet_q <= (QuietW'(cnt) + QuietW'(cfg_i.repeater_pixel)) * QuietW'(cfg_i.idle_cost_q4);
    end
    if (cmd_i.fn_sum) begin
      est_q    <= est_c;
      rnd_q    <= est_c + EstW'(RoundHalf);
      thresh_q <= (ThrW'(budget_eff) << 12) - (ThrW'(budget_eff) << 4);
      avail_q  <= (b16 > AvailW'(quiet_q)) ? b16 - AvailW'(quiet_q) : '0;
      sum_nz_q <= sum_q != '0;
    end
    if (cmd_i.fn_check) begin
      use_div_q <= need_div_c;
    end
    if (cmd_i.accept) begin
      res_ch_q  <= '0;
      res_idx_q <= '0;
    end else if (cmd_i.ld_store) begin
      res_idx_q <= 8'(lp_q);
    end else if (cmd_i.rd_fetch) begin
      res_idx_q <= 8'(rp_eff);
    end else if (cmd_i.rd_round) begin
      res_ch_q <= dim_c;
    end
    if (cmd_i.out_load) begin
      out_ch_q  <= res_ch_q;
      out_idx_q <= res_idx_q;
      out_cur_q <= cur_q;
      out_lim_q <= lim_q;
    end
  end

  assign res_ch_o     = out_ch_q;
  assign res_idx_o    = out_idx_q;
  assign current_ma_o = out_cur_q;
  assign limited_o    = out_lim_q;

  `LFGPL_ASSERT(a_dp_store_in_frame, cmd_i.ld_store |-> (lp_q < cnt), "store past frame end")

endmodule

// ===== rtl/lfgpl_ctrl.sv =====
// Controller: sequences load, finish and read words through the datapath
`include "led_frame_gamma_power_limiter_unit_macros.svh"
module lfgpl_ctrl import lfgpl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  cmd_e     in_command_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    ST_IDLE      = 14'h0001,
    ST_LD_MUL    = 14'h0002,
    ST_LD_SCALE  = 14'h0004,
    ST_LD_SQR    = 14'h0008,
    ST_LD_STORE  = 14'h0010,
    ST_FN_MUL    = 14'h0020,
    ST_FN_SUM    = 14'h0040,
    ST_FN_CHECK  = 14'h0080,
    ST_FN_DIV    = 14'h0100,
    ST_FN_COMMIT = 14'h0200,
    ST_RD_FETCH  = 14'h0400,
    ST_RD_MUL    = 14'h0800,
    ST_RD_ROUND  = 14'h1000,
    ST_EMIT      = 14'h2000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (in_command_i)
            CMD_LOAD:   state_d = stat_i.load_ok ? ST_LD_MUL : ST_EMIT;
            CMD_FINISH: state_d = ST_FN_MUL;
            CMD_READ:   state_d = ST_RD_FETCH;
            default:    state_d = ST_EMIT;
          endcase
        end
      end
      ST_LD_MUL: begin
        cmd_o.ld_mul = 1'b1;
        state_d      = ST_LD_SCALE;
      end
      ST_LD_SCALE: begin
        cmd_o.ld_scale = 1'b1;
        state_d        = ST_LD_SQR;
      end
      ST_LD_SQR: begin
        cmd_o.ld_sqr = 1'b1;
        state_d      = ST_LD_STORE;
      end
      ST_LD_STORE: begin
        cmd_o.ld_store = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_FN_MUL: begin
        cmd_o.fn_mul = 1'b1;
        state_d      = ST_FN_SUM;
      end
      ST_FN_SUM: begin
        cmd_o.fn_sum = 1'b1;
        state_d      = ST_FN_CHECK;
      end
      ST_FN_CHECK: begin
        cmd_o.fn_check = 1'b1;
        state_d        = stat_i.need_div ? ST_FN_DIV : ST_FN_COMMIT;
      end
      ST_FN_DIV: begin
        cmd_o.fn_div = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_FN_COMMIT;
        end
      end
      ST_FN_COMMIT: begin
        cmd_o.fn_commit = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_RD_FETCH: begin
        cmd_o.rd_fetch = 1'b1;
        state_d        = ST_RD_MUL;
      end
      ST_RD_MUL: begin
        cmd_o.rd_mul = 1'b1;
        state_d      = ST_RD_ROUND;
      end
      ST_RD_ROUND: begin
        cmd_o.rd_round = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `LFGPL_ASSERT(a_ctrl_finish_path, (state_q == ST_IDLE) && in_valid_i && (in_command_i == CMD_FINISH) |=> (state_q == ST_FN_MUL), "finish word not sequenced")
  `LFGPL_ASSERT(a_ctrl_valid_from_emit, $rose(out_valid_q) |-> $past(state_q == ST_EMIT), "result shown outside emit")

endmodule

// ===== rtl/led_frame_gamma_power_limiter_unit.sv =====
// Top level of the RGBW frame gamma and power limiter
//
//  port      dir   protocol    carries
//  in_if     in    valid/ready command word: command, red/green/blue/white_in
//  out_if    out   valid/ready result word: four channels, pixel_index, current_ma, limited
//  apb       in    APB         six configuration registers at 4*i
//
// Load word: multiply, scale, square, store, all four channels side by side. Read word:
// store read, ratio multiply, round. Unused command or load past the frame: straight to
// emit. Finish word: multiply, sum, check and commit, with the 16-step serial divider
// before the commit on a dimmed frame whose ratio needs it. Reset clears pointers, sums,
// ratio, current estimate and limit flag; the pixel store holds nothing until loaded.
// A stalled result waits in the output register while the next word is accepted.
module led_frame_gamma_power_limiter_unit import lfgpl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lfgpl_in_if.sink          in_if,
  lfgpl_out_if.source       out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t            cfg;
  dp_cmd_t         dp_cmd;
  dp_stat_t        dp_stat;
  logic [3:0][7:0] pix, res_ch;

  assign pix[0] = in_if.red_in;
  assign pix[1] = in_if.green_in;
  assign pix[2] = in_if.blue_in;
  assign pix[3] = in_if.white_in;

  lfgpl_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  lfgpl_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i   (in_if.valid),
    .in_command_i (cmd_e'(in_if.command)),
    .in_ready_o   (in_if.ready),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd)
  );

  lfgpl_dp u_dp (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .pix_i        (pix),
    .res_ch_o     (res_ch),
    .res_idx_o    (out_if.pixel_index),
    .current_ma_o (out_if.current_ma),
    .limited_o    (out_if.limited)
  );

  assign out_if.red_out   = res_ch[0];
  assign out_if.green_out = res_ch[1];
  assign out_if.blue_out  = res_ch[2];
  assign out_if.white_out = res_ch[3];

endmodule
